// File: sv/dksa_pkg.sv
// Package for the debounced keypad setpoint adjuster.
// Holds key codes, register indexes, timing constants and shared structs.
// No dependencies.
package dksa_pkg;

  localparam int KeyW  = 2;
  localparam int SpW   = 13;
  localparam int DelW  = 8;
  localparam int CorrW = 8;
  localparam int ViewW = 3;
  localparam int CntW  = 4;
  localparam int RepW  = 7;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 13;

  localparam logic [KeyW-1:0] KEY_NONE  = 2'd0;
  localparam logic [KeyW-1:0] KEY_MINUS = 2'd1;
  localparam logic [KeyW-1:0] KEY_PLUS  = 2'd2;
  localparam logic [KeyW-1:0] KEY_BOTH  = 2'd3;

  localparam logic [ViewW-1:0] VIEW_SETPOINT = 3'd1;
  localparam logic [ViewW-1:0] VIEW_DELTA    = 3'd2;
  localparam logic [ViewW-1:0] VIEW_CORR     = 3'd3;

  localparam logic [CntW-1:0] PRESS_TICKS   = 4'd4;
  localparam logic [CntW-1:0] RELEASE_TICKS = 4'd4;
  localparam logic [RepW-1:0] FIRST_REPEAT  = 7'd80;
  localparam logic [RepW-1:0] NEXT_REPEAT   = 7'd8;
  localparam logic [RepW-1:0] REPEAT_RESET  = 7'd40;

  localparam logic signed [SpW-1:0] SP_STEP = 13'sd5;

  localparam logic [CfgIdxW-1:0] REG_SP_MIN    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SP_MAX    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DELTA_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DELTA_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CORR_MIN  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CORR_MAX  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VIEW_LAST = 3'd6;

  typedef struct packed {
    logic signed [SpW-1:0]   sp_min;
    logic signed [SpW-1:0]   sp_max;
    logic [DelW-1:0]         delta_min;
    logic [DelW-1:0]         delta_max;
    logic signed [CorrW-1:0] corr_min;
    logic signed [CorrW-1:0] corr_max;
    logic [ViewW-1:0]        view_last;
  } cfg_t;

  typedef struct packed {
    logic            fire;
    logic [KeyW-1:0] code;
  } key_evt_t;

endpackage

// File: sv/debounced_keypad_setpoint_adjust.sv
// Debounced keypad setpoint adjuster: top level with config registers and output stage.
// Depends on dksa_pkg, dksa_debounce and dksa_adjust.
// An accepted scan item's result item is registered and shows in the next cycle.
// Throughput: one item per cycle unless stalled; output reg frees when its item is taken.
// Reset: synchronous, active low; config returns to its defaults, values and scan counters
// clear, and the repeat counter loads 40.
module debounced_keypad_setpoint_adjust (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dksa_pkg::KeyW-1:0]         in_keys_pressed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_key_event,
  output logic [dksa_pkg::KeyW-1:0]         out_event_code,
  output logic [dksa_pkg::ViewW-1:0]        out_view,
  output logic signed [dksa_pkg::SpW-1:0]   out_setpoint,
  output logic [dksa_pkg::DelW-1:0]         out_hysteresis,
  output logic signed [dksa_pkg::CorrW-1:0] out_correction,
  input  logic                              cfg_we,
  input  logic [dksa_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [dksa_pkg::CfgDataW-1:0]     cfg_wdata
);

  dksa_pkg::cfg_t     cfg_r;
  dksa_pkg::key_evt_t evt;
  logic               adv;
  logic               out_valid_r;
  logic               evt_fire_r;
  logic [dksa_pkg::KeyW-1:0] evt_code_r;

  // hold the input while a finished item waits downstream
  assign in_stall = out_valid_r & out_stall;
  assign adv      = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sp_min    <= 13'sd0;
      cfg_r.sp_max    <= 13'sd1000;
      cfg_r.delta_min <= 8'd1;
      cfg_r.delta_max <= 8'd50;
      cfg_r.corr_min  <= -8'sd50;
      cfg_r.corr_max  <= 8'sd50;
      cfg_r.view_last <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        dksa_pkg::REG_SP_MIN:    cfg_r.sp_min    <= cfg_wdata;
        dksa_pkg::REG_SP_MAX:    cfg_r.sp_max    <= cfg_wdata;
        dksa_pkg::REG_DELTA_MIN: cfg_r.delta_min <= cfg_wdata[dksa_pkg::DelW-1:0];
        dksa_pkg::REG_DELTA_MAX: cfg_r.delta_max <= cfg_wdata[dksa_pkg::DelW-1:0];
        dksa_pkg::REG_CORR_MIN:  cfg_r.corr_min  <= cfg_wdata[dksa_pkg::CorrW-1:0];
        dksa_pkg::REG_CORR_MAX:  cfg_r.corr_max  <= cfg_wdata[dksa_pkg::CorrW-1:0];
        dksa_pkg::REG_VIEW_LAST: cfg_r.view_last <= cfg_wdata[dksa_pkg::ViewW-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  dksa_debounce u_debounce (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .key   (in_keys_pressed),
    .evt   (evt)
  );

  // value registers double as the result payload: they only move on accept
  dksa_adjust u_adjust (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .evt        (evt),
    .cfg        (cfg_r),
    .view       (out_view),
    .setpoint   (out_setpoint),
    .delta      (out_hysteresis),
    .correction (out_correction)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      evt_fire_r <= evt.fire;
      evt_code_r <= evt.code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_event  = evt_fire_r;
  assign out_event_code = evt_code_r;

endmodule

// File: sv/dksa_debounce.sv
// Key debouncer with auto-repeat: wait, check and release-wait states.
// Depends on dksa_pkg. Emits at most one key event per accepted scan tick.
module dksa_debounce (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [dksa_pkg::KeyW-1:0] key,
  output dksa_pkg::key_evt_t       evt
);

  typedef enum logic [1:0] {
    ST_WAIT    = 2'd0,
    ST_CHECK   = 2'd1,
    ST_RELEASE = 2'd2
  } scan_state_t;

  scan_state_t                 state_r, state_nxt;
  logic [dksa_pkg::KeyW-1:0]  cand_r, cand_nxt;
  logic [dksa_pkg::KeyW-1:0]  acc_r, acc_nxt;
  logic [dksa_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic [dksa_pkg::RepW-1:0]  rep_r, rep_nxt;
  logic [dksa_pkg::CntW-1:0]  cnt_dec;
  logic                        fire;

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rep_nxt   = rep_r;
    fire      = 1'b0;
    cnt_dec   = cnt_r - 4'd1;
    case (state_r)
      ST_CHECK: begin
        if (key == cand_r) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            fire      = 1'b1;
            acc_nxt   = cand_r;
            state_nxt = ST_RELEASE;
            cnt_nxt   = dksa_pkg::RELEASE_TICKS;
            rep_nxt   = dksa_pkg::FIRST_REPEAT;
          end
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_RELEASE: begin
        if (key != dksa_pkg::KEY_NONE) begin
          cnt_nxt = dksa_pkg::RELEASE_TICKS;
          // repeat fires when the counter has run out; reload and count this tick
          if (rep_r == '0) begin
            fire    = 1'b1;
            rep_nxt = dksa_pkg::NEXT_REPEAT - 7'd1;
          end else begin
            rep_nxt = rep_r - 7'd1;
          end
        end else begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            state_nxt = ST_WAIT;
            rep_nxt   = dksa_pkg::FIRST_REPEAT;
          end
        end
      end
      default: begin
        // unused encoding behaves as wait
        state_nxt = ST_WAIT;
        if (key != dksa_pkg::KEY_NONE) begin
          cand_nxt  = key;
          cnt_nxt   = dksa_pkg::PRESS_TICKS;
          state_nxt = ST_CHECK;
        end
      end
    endcase
  end

  assign evt.fire = fire;
  assign evt.code = fire ? acc_nxt : dksa_pkg::KEY_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      cand_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      rep_r   <= dksa_pkg::REPEAT_RESET;
    end else if (adv) begin
      state_r <= state_nxt;
      cand_r  <= cand_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rep_r   <= rep_nxt;
    end
  end

endmodule

// File: sv/dksa_adjust.sv
// View and value registers adjusted by key events within configured limits.
// Depends on dksa_pkg for the config and event structs.
module dksa_adjust (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  dksa_pkg::key_evt_t                evt,
  input  dksa_pkg::cfg_t                    cfg,
  output logic [dksa_pkg::ViewW-1:0]        view,
  output logic signed [dksa_pkg::SpW-1:0]   setpoint,
  output logic [dksa_pkg::DelW-1:0]         delta,
  output logic signed [dksa_pkg::CorrW-1:0] correction
);

  logic [dksa_pkg::ViewW-1:0]        view_r, view_nxt;
  logic signed [dksa_pkg::SpW-1:0]   sp_r, sp_nxt;
  logic [dksa_pkg::DelW-1:0]         del_r, del_nxt;
  logic signed [dksa_pkg::CorrW-1:0] corr_r, corr_nxt;

  logic signed [dksa_pkg::SpW:0]   sp_dec, sp_inc;
  logic signed [dksa_pkg::SpW+1:0] sp_guard, sp_wide;
  logic [dksa_pkg::ViewW:0]        view_inc;

  always_comb begin
    sp_dec   = {sp_r[dksa_pkg::SpW-1], sp_r} - {dksa_pkg::SP_STEP[dksa_pkg::SpW-1],
                                                 dksa_pkg::SP_STEP};
    sp_inc   = {sp_r[dksa_pkg::SpW-1], sp_r} + {dksa_pkg::SP_STEP[dksa_pkg::SpW-1],
                                                 dksa_pkg::SP_STEP};
    // raise guard: setpoint below max minus delta
    sp_guard = {{2{cfg.sp_max[dksa_pkg::SpW-1]}}, cfg.sp_max} - {7'd0, del_r};
    sp_wide  = {{2{sp_r[dksa_pkg::SpW-1]}}, sp_r};
    view_inc = {1'b0, view_r} + 4'd1;

    view_nxt = view_r;
    sp_nxt   = sp_r;
    del_nxt  = del_r;
    corr_nxt = corr_r;

    if (evt.fire) begin
      case (evt.code)
        dksa_pkg::KEY_MINUS: begin
          if (view_r == dksa_pkg::VIEW_SETPOINT) begin
            if (sp_r > cfg.sp_min) begin
              // saturate at the bottom of the 13-bit range
              if (sp_dec[dksa_pkg::SpW] != sp_dec[dksa_pkg::SpW-1])
                sp_nxt = {1'b1, {(dksa_pkg::SpW-1){1'b0}}};
              else
                sp_nxt = sp_dec[dksa_pkg::SpW-1:0];
            end
          end else if (view_r == dksa_pkg::VIEW_DELTA) begin
            if (del_r > cfg.delta_min) del_nxt = del_r - 8'd1;
          end else if (view_r == dksa_pkg::VIEW_CORR) begin
            if (corr_r > cfg.corr_min) corr_nxt = corr_r - 8'sd1;
          end
        end
        dksa_pkg::KEY_PLUS: begin
          if (view_r == dksa_pkg::VIEW_SETPOINT) begin
            if (sp_wide < sp_guard) begin
              if (sp_inc[dksa_pkg::SpW] != sp_inc[dksa_pkg::SpW-1])
                sp_nxt = {1'b0, {(dksa_pkg::SpW-1){1'b1}}};
              else
                sp_nxt = sp_inc[dksa_pkg::SpW-1:0];
            end
          end else if (view_r == dksa_pkg::VIEW_DELTA) begin
            if (del_r < cfg.delta_max) del_nxt = del_r + 8'd1;
          end else if (view_r == dksa_pkg::VIEW_CORR) begin
            if (corr_r < cfg.corr_max) corr_nxt = corr_r + 8'sd1;
          end
        end
        dksa_pkg::KEY_BOTH: begin
          // advance view, wrap past the last one back to the setpoint view
          if (view_inc > {1'b0, cfg.view_last})
            view_nxt = dksa_pkg::VIEW_SETPOINT;
          else
            view_nxt = view_inc[dksa_pkg::ViewW-1:0];
        end
        default: begin
          view_nxt = view_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
      sp_r   <= '0;
      del_r  <= '0;
      corr_r <= '0;
    end else if (adv) begin
      view_r <= view_nxt;
      sp_r   <= sp_nxt;
      del_r  <= del_nxt;
      corr_r <= corr_nxt;
    end
  end

  assign view       = view_r;
  assign setpoint   = sp_r;
  assign delta      = del_r;
  assign correction = corr_r;

endmodule
